// ===== hw/rtl/lfukc_pkg.sv =====
// shared types and constants for the lfu key cache heap
package lfukc_pkg;

  localparam int KEY_W = 64;
  localparam int TOT_W = 32;
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [KEY_W-1:0] key_high;
    logic [KEY_W-1:0] key_low;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key_high;
    logic [KEY_W-1:0] evicted_key_low;
    logic [TOT_W-1:0] hit_total;
    logic [TOT_W-1:0] miss_total;
  } out_item_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE    = 4'd0,
    OP_START   = 4'd1,
    OP_SCAN    = 4'd2,
    OP_HIT     = 4'd3,
    OP_EVICT   = 4'd4,
    OP_APPEND  = 4'd5,
    OP_DN_RD   = 4'd6,
    OP_DN_CMP  = 4'd7,
    OP_UP_RD   = 4'd8,
    OP_UP_CMP  = 4'd9,
    OP_SWAP_A  = 4'd10,
    OP_SWAP_B  = 4'd11,
    OP_RD_LAST = 4'd12,
    OP_MV_LAST = 4'd13,
    OP_FINISH  = 4'd14
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic full;
    logic move_on;
  } stat_t;

endpackage

// ===== hw/rtl/lfukc_datapath.sv =====
// heap memories, pointers, compare logic and totals
module lfukc_datapath #(
  parameter int CAPACITY    = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfukc_pkg::cmd_t        cmd,
  output lfukc_pkg::stat_t       stat,
  input  lfukc_pkg::in_item_t    in_item,
  input  logic                   cfg_we,
  input  logic [6:0]             cfg_wdata,
  output lfukc_pkg::out_item_t   res
);
  import lfukc_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int OW = $clog2(CAPACITY + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef struct packed {
    logic [KEY_W-1:0]       kh;
    logic [KEY_W-1:0]       kl;
    logic [COUNT_WIDTH-1:0] cnt;
  } ent_t;

  ent_t mem [CAPACITY];

  logic [CFG_W-1:0] cap_r;
  logic [OW-1:0]    occ_r, occ_nxt;
  logic [OW-1:0]    lim;
  logic [TOT_W-1:0] hit_r, hit_nxt, miss_r, miss_nxt;
  logic [OW-1:0]    pos_r, pos_nxt;   // current node
  logic [OW-1:0]    pick_r, pick_nxt; // other node for swap
  logic [OW-1:0]    ra_r, ra_nxt;     // read address
  logic [1:0]       phase_r, phase_nxt;
  logic             found_r, found_nxt, ev_r, ev_nxt;
  logic             done_r, done_nxt, move_r, move_nxt;
  ent_t             rd_r, cur_r, cur_nxt, oth_r, oth_nxt, lf_r, lf_nxt;
  logic [KEY_W-1:0] evh_r, evh_nxt, evl_r, evl_nxt;
  logic             we;
  logic [AW-1:0]    wa;
  ent_t             wd;
  logic [OW:0]      lft, rgt;
  logic [OW-1:0]    par;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= CAP_RESET;
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  always_comb begin
    if (cap_r == '0) lim = OW'(1);
    else if ({{(OW+8){1'b0}}, cap_r} > (OW+8+CFG_W)'(CAPACITY)) lim = OW'(CAPACITY);
    else lim = OW'(cap_r);
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra_r[AW-1:0]];
  end

  assign lft = {pos_r, 1'b1};
  assign rgt = {pos_r, 1'b0} + (OW+1)'(2);
  assign par = OW'(((OW+1)'(pos_r) + (OW+1)'(1)) >> 1) - OW'(1);

  always_comb begin
    occ_nxt = occ_r; hit_nxt = hit_r; miss_nxt = miss_r;
    pos_nxt = pos_r; pick_nxt = pick_r; ra_nxt = ra_r; phase_nxt = phase_r;
    found_nxt = found_r; ev_nxt = ev_r; done_nxt = 1'b0; move_nxt = 1'b0;
    cur_nxt = cur_r; oth_nxt = oth_r; lf_nxt = lf_r;
    evh_nxt = evh_r; evl_nxt = evl_r;
    we = 1'b0; wa = '0; wd = cur_r;
    case (cmd.op)
      OP_START: begin
        ra_nxt = '0; pos_nxt = '0; found_nxt = 1'b0; ev_nxt = 1'b0;
        evh_nxt = '0; evl_nxt = '0; phase_nxt = 2'd0;
        done_nxt = (occ_r == '0);
      end
      OP_SCAN: begin
        // ra_r leads pos_r by one entry to cover the read register
        if (phase_r == 2'd0) begin
          phase_nxt = 2'd1; ra_nxt = ra_r + OW'(1);
        end else begin
          if (rd_r.kh == in_item.key_high && rd_r.kl == in_item.key_low) begin
            found_nxt = 1'b1; done_nxt = 1'b1; cur_nxt = rd_r;
          end else if (pos_r + OW'(1) >= occ_r) begin
            done_nxt = 1'b1;
          end else begin
            pos_nxt = pos_r + OW'(1); ra_nxt = ra_r + OW'(1);
          end
        end
      end
      OP_HIT: begin
        if (hit_r != '1) hit_nxt = hit_r + TOT_W'(1);
        if (cur_r.cnt != CNT_MAX) cur_nxt.cnt = cur_r.cnt + COUNT_WIDTH'(1);
        we = 1'b1; wa = pos_r[AW-1:0];
        wd = cur_r;
        if (cur_r.cnt != CNT_MAX) wd.cnt = cur_r.cnt + COUNT_WIDTH'(1);
        phase_nxt = 2'd0;
      end
      OP_RD_LAST: begin
        if (miss_r != '1) miss_nxt = miss_r + TOT_W'(1);
        ra_nxt = '0; phase_nxt = 2'd0;
        move_nxt = (occ_r >= lim);
      end
      OP_EVICT: begin
        // phase0 wait root, phase1 capture root and read last
        if (phase_r == 2'd0) begin
          phase_nxt = 2'd1; ra_nxt = occ_r - OW'(1);
        end else if (phase_r == 2'd1) begin
          ev_nxt = 1'b1; evh_nxt = rd_r.kh; evl_nxt = rd_r.kl; phase_nxt = 2'd2;
        end else begin
          move_nxt = 1'b1;
        end
      end
      OP_MV_LAST: begin
        we = 1'b1; wa = '0; wd = rd_r; cur_nxt = rd_r;
        occ_nxt = occ_r - OW'(1); pos_nxt = '0; phase_nxt = 2'd0;
      end
      OP_DN_RD: begin
        // read left then right children
        if (phase_r == 2'd0) begin
          ra_nxt = OW'(lft); phase_nxt = 2'd1;
          pick_nxt = pos_r; oth_nxt = cur_r;
        end else if (phase_r == 2'd1) begin
          ra_nxt = OW'(rgt); phase_nxt = 2'd2;
        end else begin
          lf_nxt = rd_r; phase_nxt = 2'd3;
        end
      end
      OP_DN_CMP: begin
        pick_nxt = pos_r; oth_nxt = cur_r; move_nxt = 1'b0;
        if (lft < (OW+1)'(occ_r) && lf_r.cnt < cur_r.cnt) begin
          pick_nxt = OW'(lft); oth_nxt = lf_r;
        end
        if (rgt < (OW+1)'(occ_r)) begin
          if (lft < (OW+1)'(occ_r) && lf_r.cnt < cur_r.cnt) begin
            if (rd_r.cnt < lf_r.cnt) begin pick_nxt = OW'(rgt); oth_nxt = rd_r; end
          end else if (rd_r.cnt < cur_r.cnt) begin
            pick_nxt = OW'(rgt); oth_nxt = rd_r;
          end
        end
        move_nxt = !((lft < (OW+1)'(occ_r) && lf_r.cnt < cur_r.cnt) ||
                     (rgt < (OW+1)'(occ_r) && rd_r.cnt < cur_r.cnt &&
                      !(lft < (OW+1)'(occ_r) && lf_r.cnt < cur_r.cnt && !(rd_r.cnt < lf_r.cnt))))
                   ? 1'b0 : 1'b1;
        phase_nxt = 2'd0;
      end
      OP_SWAP_A: begin
        we = 1'b1; wa = pos_r[AW-1:0]; wd = oth_r;
      end
      OP_SWAP_B: begin
        we = 1'b1; wa = pick_r[AW-1:0]; wd = cur_r; pos_nxt = pick_r;
      end
      OP_APPEND: begin
        cur_nxt.kh = in_item.key_high; cur_nxt.kl = in_item.key_low;
        cur_nxt.cnt = COUNT_WIDTH'(1);
        we = 1'b1; wa = occ_r[AW-1:0];
        wd = cur_nxt;
        pos_nxt = occ_r; occ_nxt = occ_r + OW'(1); phase_nxt = 2'd0;
      end
      OP_UP_RD: begin
        if (phase_r == 2'd0) begin
          ra_nxt = par; phase_nxt = 2'd1;
        end else begin
          phase_nxt = 2'd3;
        end
        move_nxt = (pos_r != '0);
      end
      OP_UP_CMP: begin
        pick_nxt = par; oth_nxt = rd_r; phase_nxt = 2'd0;
        move_nxt = (cur_r.cnt < rd_r.cnt);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0; hit_r <= '0; miss_r <= '0; phase_r <= '0;
      done_r <= 1'b0; move_r <= 1'b0; found_r <= 1'b0; ev_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt; hit_r <= hit_nxt; miss_r <= miss_nxt; phase_r <= phase_nxt;
      done_r <= done_nxt; move_r <= move_nxt; found_r <= found_nxt; ev_r <= ev_nxt;
    end
    pos_r <= pos_nxt; pick_r <= pick_nxt; ra_r <= ra_nxt;
    cur_r <= cur_nxt; oth_r <= oth_nxt; lf_r <= lf_nxt;
    evh_r <= evh_nxt; evl_r <= evl_nxt;
  end

  assign stat.scan_done = done_r;
  assign stat.found     = found_r;
  assign stat.full      = (phase_r == 2'd3);
  assign stat.move_on   = move_r;

  assign res.hit              = found_r;
  assign res.evicted          = ev_r;
  assign res.evicted_key_high = evh_r;
  assign res.evicted_key_low  = evl_r;
  assign res.hit_total        = hit_r;
  assign res.miss_total       = miss_r;

`ifndef SYNTHESIS
  a_occ_cap: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(CAPACITY)) else $error("occupancy above capacity");
  a_hit_mono: assert property (@(posedge clk) disable iff (!rst_n)
    hit_r >= $past(hit_r)) else $error("hit total went down");
  a_miss_mono: assert property (@(posedge clk) disable iff (!rst_n)
    miss_r >= $past(miss_r)) else $error("miss total went down");
`endif

endmodule

// ===== hw/rtl/lfukc_ctrl.sv =====
// sequencer for lookup, eviction and heap sifts
module lfukc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              item_load,
  output lfukc_pkg::cmd_t   cmd,
  input  lfukc_pkg::stat_t  stat
);
  import lfukc_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_START  = 14'b00000000000010,
    S_SCAN   = 14'b00000000000100,
    S_HIT    = 14'b00000000001000,
    S_MISS   = 14'b00000000010000,
    S_EVICT  = 14'b00000000100000,
    S_MVLAST = 14'b00000001000000,
    S_DNRD   = 14'b00000010000000,
    S_DNCMP  = 14'b00000100000000,
    S_SWA    = 14'b00001000000000,
    S_SWB    = 14'b00010000000000,
    S_APPEND = 14'b00100000000000,
    S_UPRD   = 14'b01000000000000,
    S_OUT    = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   up_r, up_nxt;     // current sift direction is up
  logic   app_r, app_nxt;   // append follows the down sift
  logic   cmp_r, cmp_nxt;   // up sift waiting to compare

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign item_load = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r; up_nxt = up_r; app_nxt = app_r; cmp_nxt = cmp_r;
    cmd.op = OP_NONE;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_START;
      S_START: begin cmd.op = OP_START; state_nxt = S_SCAN; end
      S_SCAN: begin
        if (stat.scan_done) state_nxt = stat.found ? S_HIT : S_MISS;
        else cmd.op = OP_SCAN;
      end
      S_HIT: begin
        cmd.op = OP_HIT; up_nxt = 1'b0; app_nxt = 1'b0; state_nxt = S_DNRD;
      end
      S_MISS: begin cmd.op = OP_RD_LAST; state_nxt = S_EVICT; end
      S_EVICT: begin
        if (!stat.move_on && !stat.full) begin
          // first cycle after miss: move_on tells if cache is full
          state_nxt = S_APPEND;
        end else begin
          cmd.op = OP_EVICT;
          state_nxt = S_MVLAST;
        end
      end
      S_MVLAST: begin
        cmd.op = OP_EVICT;
        if (stat.move_on) begin
          cmd.op = OP_MV_LAST; up_nxt = 1'b0; app_nxt = 1'b1; state_nxt = S_DNRD;
        end
      end
      S_DNRD: begin
        cmd.op = OP_DN_RD;
        if (stat.full) begin cmd.op = OP_DN_CMP; state_nxt = S_DNCMP; end
      end
      S_DNCMP: begin
        if (stat.move_on) state_nxt = S_SWA;
        else state_nxt = app_r ? S_APPEND : S_OUT;
      end
      S_SWA: begin cmd.op = OP_SWAP_A; state_nxt = S_SWB; end
      S_SWB: begin
        cmd.op = OP_SWAP_B;
        state_nxt = up_r ? S_UPRD : S_DNRD;
        cmp_nxt = 1'b0;
      end
      S_APPEND: begin
        cmd.op = OP_APPEND; up_nxt = 1'b1; app_nxt = 1'b0; cmp_nxt = 1'b0;
        state_nxt = S_UPRD;
      end
      S_UPRD: begin
        if (stat.full) begin
          // parent entry is in the read register
          cmd.op = OP_UP_CMP; cmp_nxt = 1'b0;
          state_nxt = S_DNCMP;
        end else if (!cmp_r) begin
          cmd.op = OP_UP_RD; cmp_nxt = 1'b1;
        end else if (!stat.move_on) begin
          state_nxt = S_OUT;
        end else begin
          cmd.op = OP_UP_RD;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; up_r <= 1'b0; app_r <= 1'b0; cmp_r <= 1'b0;
    end else begin
      state_r <= state_nxt; up_r <= up_nxt; app_r <= app_nxt; cmp_r <= cmp_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
`endif

endmodule

// ===== hw/rtl/lfu_key_cache_heap_unit.sv =====
// top level of the lfu key cache heap unit
//   channel  direction  handshake
//   in_      input      in_valid / in_ready, key halves
//   out_     output     out_valid / out_ready, result struct
//   cfg_     input      cfg_we / cfg_wdata, capacity limit
// one transaction at a time: a lookup scans the entries over one memory read
// port, then a hit bumps the hit total and the entry's count and sifts it down;
// a miss bumps the miss total and, when full, evicts the root and moves the last
// entry there to sift down; it then appends the key and sifts it up, at most to the root.
// synchronous active-low reset clears occupancy, totals and capacity to 64.
// a stalled result holds the unit; no new input is taken until it leaves.
module lfu_key_cache_heap_unit #(
  parameter int CAPACITY    = 64,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lfukc_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lfukc_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_wdata
);
  import lfukc_pkg::*;

  cmd_t     cmd;
  stat_t    stat;
  in_item_t item_r;
  logic     item_load;

  always_ff @(posedge clk) begin
    if (item_load) item_r <= in_data;
  end

  lfukc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .item_load(item_load),
    .cmd(cmd), .stat(stat)
  );

  lfukc_datapath #(.CAPACITY(CAPACITY), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .in_item(item_r),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .res(out_data)
  );

endmodule
